### sv/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/cbp_pkg.sv
// Types, constants and helper functions of the cascaded balance PID core.
package cbp_pkg;

    localparam int GAIN_W  = 32;  // all gains, Q16
    localparam int SPEED_W = 24;  // wheel speed and setpoint, Q8
    localparam int ANGLE_W = 17;  // pitch angle and offset, Q8
    localparam int RATE_W  = 16;  // raw gyro reading
    localparam int LIM_W   = 23;  // integral clamp, Q8
    localparam int DRV_W   = 16;  // drive and correction outputs
    localparam int E_W     = SPEED_W + 1;   // speed error
    localparam int SUM_W   = 40;            // error sum
    localparam int HALF_W  = SUM_W / 2;     // sum split for the shared multiplier
    localparam int MB_W    = 26;            // multiplier operand B
    localparam int PROD_W  = GAIN_W + MB_W; // multiplier product
    localparam int ACC_W   = 74;            // Q24 accumulator
    localparam int Q_W     = ACC_W - 24;    // accumulator integer part
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [DRV_W-1:0] DRV_MAX = {1'b0, {(DRV_W-1){1'b1}}};
    localparam logic signed [DRV_W-1:0] DRV_MIN = {1'b1, {(DRV_W-1){1'b0}}};

    // Reset values of the configuration registers
    localparam logic signed [SPEED_W-1:0] SPEED_SETPOINT_RST = '0;
    localparam logic signed [GAIN_W-1:0]  SPEED_KP_RST       = -32'sd54067;
    localparam logic signed [GAIN_W-1:0]  SPEED_KI_RST       = -32'sd270;
    localparam logic [LIM_W-1:0]          SPEED_LIMIT_RST    = 23'd768;
    localparam logic signed [GAIN_W-1:0]  ANGLE_KP_RST       = 32'sd4501012;
    localparam logic signed [GAIN_W-1:0]  ANGLE_KD_RST       = 32'sd11796;
    localparam logic signed [ANGLE_W-1:0] ANGLE_OFFSET_RST   = -17'sd589;

    typedef enum logic [2:0] {
        REG_SPEED_SETPOINT = 3'd0,
        REG_SPEED_KP       = 3'd1,
        REG_SPEED_KI       = 3'd2,
        REG_SPEED_LIMIT    = 3'd3,
        REG_ANGLE_KP       = 3'd4,
        REG_ANGLE_KD       = 3'd5,
        REG_ANGLE_OFFSET   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_setpoint;
        logic signed [GAIN_W-1:0]  speed_kp;
        logic signed [GAIN_W-1:0]  speed_ki;
        logic [LIM_W-1:0]          speed_integral_limit;
        logic signed [GAIN_W-1:0]  angle_kp;
        logic signed [GAIN_W-1:0]  angle_kd;
        logic signed [ANGLE_W-1:0] angle_offset;
    } cfg_t;

    // Datapath commands, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SUM,
        OP_MUL_ILO,
        OP_MUL_IHI,
        OP_MUL_PE,
        OP_CLAMP,
        OP_ADD_P,
        OP_CORR,
        OP_MUL_AK,
        OP_MUL_KD,
        OP_ADD_D,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_MUL_PE,
        ST_CLAMP,
        ST_ADD_P,
        ST_CORR,
        ST_MUL_AK,
        ST_MUL_KD,
        ST_ADD_D,
        ST_OUT
    } state_t;

    // Q24 to integer: truncate toward zero, then saturate to 16 bits
    function automatic logic signed [DRV_W-1:0] q24_to_s16(input logic signed [ACC_W-1:0] x);
        logic signed [Q_W-1:0]   q;
        logic signed [DRV_W-1:0] r;
        begin
            q = signed'(x[ACC_W-1:24]);
            if (x[ACC_W-1] && (x[23:0] != '0)) begin
                q = q + Q_W'(1);
            end
            if (q > Q_W'(DRV_MAX)) begin
                r = DRV_MAX;
            end else if (q < Q_W'(DRV_MIN)) begin
                r = DRV_MIN;
            end else begin
                r = q[DRV_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

### sv/cbp_regs.sv
// APB-style configuration register file of the balance PID core.
module cbp_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbp_pkg::ADDR_W-1:0]  paddr,
    input  logic [cbp_pkg::DATA_W-1:0]  pwdata,
    output logic [cbp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output cbp_pkg::cfg_t               cfg
);

    cbp_pkg::cfg_t    cfg_reg;
    cbp_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = cbp_pkg::reg_idx_t'(paddr[cbp_pkg::ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_setpoint       <= cbp_pkg::SPEED_SETPOINT_RST;
            cfg_reg.speed_kp             <= cbp_pkg::SPEED_KP_RST;
            cfg_reg.speed_ki             <= cbp_pkg::SPEED_KI_RST;
            cfg_reg.speed_integral_limit <= cbp_pkg::SPEED_LIMIT_RST;
            cfg_reg.angle_kp             <= cbp_pkg::ANGLE_KP_RST;
            cfg_reg.angle_kd             <= cbp_pkg::ANGLE_KD_RST;
            cfg_reg.angle_offset         <= cbp_pkg::ANGLE_OFFSET_RST;
        end else if (wr_en) begin
            unique case (idx)
                cbp_pkg::REG_SPEED_SETPOINT:
                    cfg_reg.speed_setpoint <= signed'(pwdata[cbp_pkg::SPEED_W-1:0]);
                cbp_pkg::REG_SPEED_KP: cfg_reg.speed_kp <= signed'(pwdata);
                cbp_pkg::REG_SPEED_KI: cfg_reg.speed_ki <= signed'(pwdata);
                cbp_pkg::REG_SPEED_LIMIT:
                    cfg_reg.speed_integral_limit <= pwdata[cbp_pkg::LIM_W-1:0];
                cbp_pkg::REG_ANGLE_KP: cfg_reg.angle_kp <= signed'(pwdata);
                cbp_pkg::REG_ANGLE_KD: cfg_reg.angle_kd <= signed'(pwdata);
                cbp_pkg::REG_ANGLE_OFFSET:
                    cfg_reg.angle_offset <= signed'(pwdata[cbp_pkg::ANGLE_W-1:0]);
                default: ;
            endcase
        end
    end

    // signed registers read back sign-extended
    always_comb begin
        unique case (idx)
            cbp_pkg::REG_SPEED_SETPOINT:
                prdata = cbp_pkg::DATA_W'(cfg_reg.speed_setpoint);
            cbp_pkg::REG_SPEED_KP: prdata = cfg_reg.speed_kp;
            cbp_pkg::REG_SPEED_KI: prdata = cfg_reg.speed_ki;
            cbp_pkg::REG_SPEED_LIMIT:
                prdata = {{(cbp_pkg::DATA_W-cbp_pkg::LIM_W){1'b0}}, cfg_reg.speed_integral_limit};
            cbp_pkg::REG_ANGLE_KP: prdata = cfg_reg.angle_kp;
            cbp_pkg::REG_ANGLE_KD: prdata = cfg_reg.angle_kd;
            cbp_pkg::REG_ANGLE_OFFSET:
                prdata = cbp_pkg::DATA_W'(cfg_reg.angle_offset);
            default: prdata = '0;
        endcase
    end

endmodule

### sv/cbp_ctrl.sv
// Sequencing state machine of the balance PID core: issues one datapath step per cycle unless the output slot is full.
module cbp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output cbp_pkg::dp_op_t cmd
);

    cbp_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cbp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cbp_pkg::ST_IDLE:    if (s_valid) state_next = cbp_pkg::ST_SUM;
            cbp_pkg::ST_SUM:     state_next = cbp_pkg::ST_MUL_ILO;
            cbp_pkg::ST_MUL_ILO: state_next = cbp_pkg::ST_MUL_IHI;
            cbp_pkg::ST_MUL_IHI: state_next = cbp_pkg::ST_MUL_PE;
            cbp_pkg::ST_MUL_PE:  state_next = cbp_pkg::ST_CLAMP;
            cbp_pkg::ST_CLAMP:   state_next = cbp_pkg::ST_ADD_P;
            cbp_pkg::ST_ADD_P:   state_next = cbp_pkg::ST_CORR;
            cbp_pkg::ST_CORR:    state_next = cbp_pkg::ST_MUL_AK;
            cbp_pkg::ST_MUL_AK:  state_next = cbp_pkg::ST_MUL_KD;
            cbp_pkg::ST_MUL_KD:  state_next = cbp_pkg::ST_ADD_D;
            cbp_pkg::ST_ADD_D:   state_next = cbp_pkg::ST_OUT;
            cbp_pkg::ST_OUT:     if (out_free) state_next = cbp_pkg::ST_IDLE;
            default:             state_next = cbp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = cbp_pkg::OP_NONE;
        unique case (state_reg)
            cbp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd = cbp_pkg::OP_LOAD;
            end
            cbp_pkg::ST_SUM:     cmd = cbp_pkg::OP_SUM;
            cbp_pkg::ST_MUL_ILO: cmd = cbp_pkg::OP_MUL_ILO;
            cbp_pkg::ST_MUL_IHI: cmd = cbp_pkg::OP_MUL_IHI;
            cbp_pkg::ST_MUL_PE:  cmd = cbp_pkg::OP_MUL_PE;
            cbp_pkg::ST_CLAMP:   cmd = cbp_pkg::OP_CLAMP;
            cbp_pkg::ST_ADD_P:   cmd = cbp_pkg::OP_ADD_P;
            cbp_pkg::ST_CORR:    cmd = cbp_pkg::OP_CORR;
            cbp_pkg::ST_MUL_AK:  cmd = cbp_pkg::OP_MUL_AK;
            cbp_pkg::ST_MUL_KD:  cmd = cbp_pkg::OP_MUL_KD;
            cbp_pkg::ST_ADD_D:   cmd = cbp_pkg::OP_ADD_D;
            cbp_pkg::ST_OUT:     if (out_free) cmd = cbp_pkg::OP_OUT;
            default:             cmd = cbp_pkg::OP_NONE;
        endcase
    end

    // output slot: loads on OP_OUT, drains when the beat is taken
    always_comb begin
        if (cmd == cbp_pkg::OP_OUT) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

### sv/cbp_dp.sv
// Datapath of the balance PID core: error sum, shared multiplier, accumulator, output registers.
module cbp_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cbp_pkg::dp_op_t                     cmd,
    input  cbp_pkg::cfg_t                       cfg,
    input  logic signed [cbp_pkg::SPEED_W-1:0]  s_wheel_speed,
    input  logic signed [cbp_pkg::ANGLE_W-1:0]  s_pitch_angle,
    input  logic signed [cbp_pkg::RATE_W-1:0]   s_pitch_rate,
    output logic signed [cbp_pkg::DRV_W-1:0]    m_left_drive,
    output logic signed [cbp_pkg::DRV_W-1:0]    m_right_drive,
    output logic signed [cbp_pkg::DRV_W-1:0]    m_speed_correction
);

    localparam int SUM_X = cbp_pkg::SUM_W + 1;
    localparam int LIM_PAD = cbp_pkg::ACC_W - cbp_pkg::LIM_W - 16;

    logic signed [cbp_pkg::E_W-1:0]     e_reg, e_next;
    logic signed [cbp_pkg::ANGLE_W-1:0] pitch_reg;
    logic signed [cbp_pkg::RATE_W-1:0]  rate_reg;
    logic signed [cbp_pkg::SUM_W-1:0]   sum_reg, sum_sat;
    logic signed [SUM_X-1:0]            sum_wide;
    logic signed [cbp_pkg::PROD_W-1:0]  prod_reg, mul_p;
    logic signed [cbp_pkg::GAIN_W-1:0]  mul_a;
    logic signed [cbp_pkg::MB_W-1:0]    mul_b;
    logic signed [cbp_pkg::ACC_W-1:0]   acc_reg, prod_ext, lim_ext, neg_lim;
    logic                               clamp_hi, clamp_lo;
    logic signed [cbp_pkg::MB_W-1:0]    target, aerr;
    logic signed [cbp_pkg::DRV_W-1:0]   corr_reg, left_next, right_next;
    logic signed [cbp_pkg::DRV_W-1:0]   left_reg, right_reg, corr_out_reg;

    assign e_next = {cfg.speed_setpoint[cbp_pkg::SPEED_W-1], cfg.speed_setpoint}
                  - {s_wheel_speed[cbp_pkg::SPEED_W-1], s_wheel_speed};

    assign sum_wide = {sum_reg[cbp_pkg::SUM_W-1], sum_reg}
                    + {{(SUM_X-cbp_pkg::E_W){e_reg[cbp_pkg::E_W-1]}}, e_reg};

    always_comb begin
        if (sum_wide[SUM_X-1] != sum_wide[SUM_X-2]) begin
            sum_sat = sum_wide[SUM_X-1] ? cbp_pkg::SUM_MIN : cbp_pkg::SUM_MAX;
        end else begin
            sum_sat = sum_wide[cbp_pkg::SUM_W-1:0];
        end
    end

    // pitch setpoint = offset + correction in whole degrees
    assign target = {{(cbp_pkg::MB_W-cbp_pkg::ANGLE_W){cfg.angle_offset[cbp_pkg::ANGLE_W-1]}},
                     cfg.angle_offset}
                  + {{(cbp_pkg::MB_W-cbp_pkg::DRV_W-8){corr_reg[cbp_pkg::DRV_W-1]}},
                     corr_reg, 8'b0};
    assign aerr = {{(cbp_pkg::MB_W-cbp_pkg::ANGLE_W){pitch_reg[cbp_pkg::ANGLE_W-1]}}, pitch_reg}
                - target;

    // shared multiplier operand select
    always_comb begin
        mul_a = cfg.speed_ki;
        mul_b = '0;
        case (cmd)
            cbp_pkg::OP_MUL_ILO: begin
                mul_a = cfg.speed_ki;
                mul_b = {{(cbp_pkg::MB_W-cbp_pkg::HALF_W){1'b0}},
                         sum_reg[cbp_pkg::HALF_W-1:0]};
            end
            cbp_pkg::OP_MUL_IHI: begin
                mul_a = cfg.speed_ki;
                mul_b = {{(cbp_pkg::MB_W-cbp_pkg::HALF_W){sum_reg[cbp_pkg::SUM_W-1]}},
                         sum_reg[cbp_pkg::SUM_W-1:cbp_pkg::HALF_W]};
            end
            cbp_pkg::OP_MUL_PE: begin
                mul_a = cfg.speed_kp;
                mul_b = {{(cbp_pkg::MB_W-cbp_pkg::E_W){e_reg[cbp_pkg::E_W-1]}}, e_reg};
            end
            cbp_pkg::OP_MUL_AK: begin
                mul_a = cfg.angle_kp;
                mul_b = aerr;
            end
            cbp_pkg::OP_MUL_KD: begin
                mul_a = cfg.angle_kd;
                mul_b = {{(cbp_pkg::MB_W-cbp_pkg::RATE_W){rate_reg[cbp_pkg::RATE_W-1]}},
                         rate_reg};
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign prod_ext = {{(cbp_pkg::ACC_W-cbp_pkg::PROD_W){prod_reg[cbp_pkg::PROD_W-1]}},
                       prod_reg};
    assign lim_ext  = {{LIM_PAD{1'b0}}, cfg.speed_integral_limit, 16'b0};
    assign neg_lim  = -lim_ext;
    assign clamp_hi = acc_reg >= lim_ext;
    assign clamp_lo = acc_reg < neg_lim;

    assign left_next  = cbp_pkg::q24_to_s16(acc_reg);
    assign right_next = (left_next == cbp_pkg::DRV_MIN) ? cbp_pkg::DRV_MAX : -left_next;

    // error sum is model state: reset, saturating add, cleared on clamp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (cmd == cbp_pkg::OP_SUM) begin
            sum_reg <= sum_sat;
        end else if (cmd == cbp_pkg::OP_CLAMP && (clamp_hi || clamp_lo)) begin
            sum_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            cbp_pkg::OP_LOAD: begin
                e_reg     <= e_next;
                pitch_reg <= s_pitch_angle;
                rate_reg  <= s_pitch_rate;
            end
            cbp_pkg::OP_MUL_ILO: prod_reg <= mul_p;
            cbp_pkg::OP_MUL_IHI: begin
                prod_reg <= mul_p;
                acc_reg  <= prod_ext;
            end
            cbp_pkg::OP_MUL_PE: begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + (prod_ext <<< cbp_pkg::HALF_W);
            end
            cbp_pkg::OP_CLAMP: begin
                if (clamp_hi) begin
                    acc_reg <= lim_ext;
                end else if (clamp_lo) begin
                    acc_reg <= neg_lim;
                end
            end
            cbp_pkg::OP_ADD_P:   acc_reg  <= acc_reg + prod_ext;
            cbp_pkg::OP_CORR:    corr_reg <= left_next;
            cbp_pkg::OP_MUL_AK:  prod_reg <= mul_p;
            cbp_pkg::OP_MUL_KD: begin
                prod_reg <= mul_p;
                acc_reg  <= prod_ext;
            end
            cbp_pkg::OP_ADD_D:   acc_reg  <= acc_reg + (prod_ext <<< 8);
            cbp_pkg::OP_OUT: begin
                left_reg     <= left_next;
                right_reg    <= right_next;
                corr_out_reg <= corr_reg;
            end
            default: ;
        endcase
    end

    assign m_left_drive       = left_reg;
    assign m_right_drive      = right_reg;
    assign m_speed_correction = corr_out_reg;

endmodule

### sv/cascaded_balance_pid_core.sv
// Top level of the cascaded balance PID core: register file, controller and datapath.
//
//   channel   ports                          direction
//   s_        valid/ready, speed/angle/rate  in   one control tick per beat
//   m_        valid/ready, left/right/corr   out  one result beat per tick
//   apb       psel/penable/pwrite/paddr      in   configuration, pready tied high
//
// A new input beat is accepted only once the previous tick has finished; the 11 steps
// of the sequencer share a single 32x26 multiplier.
// aresetn is synchronous; it clears the error sum, the sequencer and the output slot.
// A finished result waits in the output register; the sequencer stalls in its last
// step only while that register still holds an untaken beat.
`include "assert_macros.svh"

module cascaded_balance_pid_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [cbp_pkg::SPEED_W-1:0]  s_wheel_speed,
    input  logic signed [cbp_pkg::ANGLE_W-1:0]  s_pitch_angle,
    input  logic signed [cbp_pkg::RATE_W-1:0]   s_pitch_rate,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [cbp_pkg::DRV_W-1:0]    m_left_drive,
    output logic signed [cbp_pkg::DRV_W-1:0]    m_right_drive,
    output logic signed [cbp_pkg::DRV_W-1:0]    m_speed_correction,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbp_pkg::ADDR_W-1:0]          paddr,
    input  logic [cbp_pkg::DATA_W-1:0]          pwdata,
    output logic [cbp_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    cbp_pkg::cfg_t   cfg;
    cbp_pkg::dp_op_t cmd;

    cbp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    cbp_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .cfg                (cfg),
        .s_wheel_speed      (s_wheel_speed),
        .s_pitch_angle      (s_pitch_angle),
        .s_pitch_rate       (s_pitch_rate),
        .m_left_drive       (m_left_drive),
        .m_right_drive      (m_right_drive),
        .m_speed_correction (m_speed_correction)
    );

    // an accepted beat starts the sequence on the next cycle
    `ASSERT_NEXT(a_accept_starts_sum, aclk, aresetn, s_valid && s_ready, cmd == cbp_pkg::OP_SUM)
    // results never overwrite an untaken beat
    `ASSERT_IMPL(a_out_slot_free, aclk, aresetn, cmd == cbp_pkg::OP_OUT, !m_valid || m_ready)
    // a loaded result is offered on the next cycle
    `ASSERT_NEXT(a_out_offered, aclk, aresetn, cmd == cbp_pkg::OP_OUT, m_valid)
    // no new tick is taken while the sequencer is busy
    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, cmd != cbp_pkg::OP_NONE && cmd != cbp_pkg::OP_LOAD, !s_ready)

endmodule
